// ----- src/lbps_pkg.sv -----
// Shared types and constants for the LED blink pattern sequencer.
// Used by the request channel interface, the duration table and the top level.
package lbps_pkg;

   localparam int REQ_W       = 2;
   localparam int ENTRY_IDX_W = 3;
   localparam int DUR_W       = 16;
   localparam int PHASE_W     = 9;
   localparam int ELAPSED_W   = 17;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Number of table slots that a load request can address at all.
   localparam int ENTRY_SLOTS = 1 << ENTRY_IDX_W;

   // Saturation limit of the fixed mode pattern length.
   localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK  = 2'd0,
      REQ_START = 2'd1,
      REQ_STOP  = 2'd2,
      REQ_LOAD  = 2'd3
   } req_kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_ENABLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_OUTPUT  = 3'd4;

   typedef struct packed {
      logic                   en;
      logic [ENTRY_IDX_W-1:0] idx;
      logic [DUR_W-1:0]       value;
   } table_wr_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] elapsed_ticks;
      logic [DUR_W-1:0]     phase_wait;
      logic [PHASE_W-1:0]   phase_index;
      logic [PHASE_W-1:0]   active_phases;
      logic                 led_on;
      logic                 active;
   } seq_state_type;

endpackage

// ----- src/lbps_req_if.sv -----
// Request channel of the LED blink pattern sequencer: valid/ready plus payload.
// Depends on lbps_pkg for the field widths.
interface lbps_req_if;
   logic                            valid;
   logic                            ready;
   logic [lbps_pkg::REQ_W-1:0]      req_type;
   logic [lbps_pkg::ENTRY_IDX_W-1:0] entry_index;
   logic [lbps_pkg::DUR_W-1:0]      entry_value;

   modport source (output valid, output req_type, output entry_index, output entry_value,
                   input ready);
   modport sink (input valid, input req_type, input entry_index, input entry_value,
                 output ready);
endinterface

// ----- src/lbps_rsp_if.sv -----
// Response channel of the LED blink pattern sequencer: valid/ready plus payload.
// Stands alone; carries the pin level and the running flag.
interface lbps_rsp_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic running;

   modport source (output valid, output pin_level, output running, input ready);
   modport sink (input valid, input pin_level, input running, output ready);
endinterface

// ----- src/lbps_table.sv -----
// Phase duration table: one write port, one combinational read port.
// Depends on lbps_pkg for widths and the write request struct.
module lbps_table #(
   parameter int TABLE_DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lbps_pkg::table_wr_type             wr,
   input  logic [lbps_pkg::PHASE_W-1:0]       rd_addr,
   output logic [lbps_pkg::DUR_W-1:0]         rd_data
);

   // Slots beyond what a load can address never leave zero, so they need no storage.
   localparam int STORE_DEPTH =
      (TABLE_DEPTH < lbps_pkg::ENTRY_SLOTS) ? TABLE_DEPTH : lbps_pkg::ENTRY_SLOTS;
   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [lbps_pkg::DUR_W-1:0] mem_ff [STORE_DEPTH];
   logic                       rd_hit;
   logic                       wr_hit;

   assign rd_hit = rd_addr < lbps_pkg::PHASE_W'(STORE_DEPTH);
   assign wr_hit = wr.en && (32'(wr.idx) < STORE_DEPTH);
   assign rd_data = rd_hit ? mem_ff[rd_addr[AW-1:0]] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            mem_ff[i] <= '0;
         end
      end else if (wr_hit) begin
         mem_ff[wr.idx[AW-1:0]] <= wr.value;
      end
   end

endmodule

// ----- src/led_blink_pattern_sequencer.sv -----
// LED blink pattern sequencer. Every request word (tick, start, stop or table load)
// is applied when it is accepted, and its response word, the pin level and running
// flag after the update, is presented in the next cycle from an output register. A
// new request word is accepted in every cycle in which the response register is empty
// or being taken, so the sustained rate is one word per clock while the response side
// is ready; the phase counter update and the duration table read are combinational.
// Depends on lbps_pkg, lbps_req_if, lbps_rsp_if and lbps_table.
module led_blink_pattern_sequencer #(
   parameter int TABLE_DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lbps_req_if.sink                             req_chan,
   lbps_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [lbps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lbps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PW = lbps_pkg::PHASE_W;

   logic                         stream_mode_ff;
   logic [lbps_pkg::DUR_W-1:0]   fixed_interval_ff;
   logic [PW-1:0]                phase_count_ff;
   logic                         repeat_enable_ff;
   logic                         invert_output_ff;

   lbps_pkg::seq_state_type      state_ff;
   lbps_pkg::seq_state_type      state_in;

   logic                         rsp_valid_ff;
   logic                         pin_level_ff;
   logic                         running_ff;

   logic                         accept;
   lbps_pkg::table_wr_type       tbl_wr;
   logic [PW-1:0]                tbl_addr;
   logic [lbps_pkg::DUR_W-1:0]   tbl_data;

   logic [PW:0]                  fixed_len;
   logic [PW-1:0]                start_len;
   logic [lbps_pkg::ELAPSED_W-1:0] elapsed_inc;
   logic [PW-1:0]                next_index;
   logic                         next_in_range;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pin_level = pin_level_ff;
   assign rsp_chan.running   = running_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stream_mode_ff    <= 1'b0;
         fixed_interval_ff <= '0;
         phase_count_ff    <= PW'(1);
         repeat_enable_ff  <= 1'b0;
         invert_output_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            lbps_pkg::CSR_STREAM_MODE:    stream_mode_ff    <= csr_wdata[0];
            lbps_pkg::CSR_FIXED_INTERVAL: fixed_interval_ff <= csr_wdata;
            lbps_pkg::CSR_PHASE_COUNT:    phase_count_ff    <= csr_wdata[PW-1:0];
            lbps_pkg::CSR_REPEAT_ENABLE:  repeat_enable_ff  <= csr_wdata[0];
            lbps_pkg::CSR_INVERT_OUTPUT:  invert_output_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign tbl_wr.en    = accept && (req_chan.req_type == lbps_pkg::REQ_LOAD);
   assign tbl_wr.idx   = req_chan.entry_index;
   assign tbl_wr.value = req_chan.entry_value;

   // The table is only ever read at the phase that is about to begin.
   assign next_index    = state_ff.phase_index + PW'(1);
   assign next_in_range = next_index < state_ff.active_phases;
   assign tbl_addr = (req_chan.req_type == lbps_pkg::REQ_START || !next_in_range)
                     ? '0 : next_index;

   lbps_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_addr (tbl_addr),
      .rd_data (tbl_data)
   );

   // Fixed mode runs count*2-1 phases, saturating at the phase counter's limit.
   assign fixed_len = {phase_count_ff, 1'b0} - (PW + 1)'(1);
   always_comb begin
      if (stream_mode_ff) begin
         start_len = (phase_count_ff > PW'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH) : phase_count_ff;
      end else if (phase_count_ff == '0) begin
         start_len = '0;
      end else if (fixed_len[PW]) begin
         start_len = lbps_pkg::PHASE_MAX;
      end else begin
         start_len = fixed_len[PW-1:0];
      end
   end

   assign elapsed_inc = state_ff.elapsed_ticks + lbps_pkg::ELAPSED_W'(1);

   always_comb begin
      state_in = state_ff;
      case (req_chan.req_type)
         lbps_pkg::REQ_TICK: begin
            // A zero duration holds the current phase for good.
            if (state_ff.active && state_ff.phase_wait != '0) begin
               if (elapsed_inc <= {1'b0, state_ff.phase_wait}) begin
                  state_in.elapsed_ticks = elapsed_inc;
               end else if (next_in_range) begin
                  state_in.phase_index   = next_index;
                  state_in.led_on        = !next_index[0];
                  state_in.elapsed_ticks = '0;
                  if (stream_mode_ff) begin
                     if (next_index < PW'(TABLE_DEPTH)) begin
                        state_in.phase_wait = tbl_data;
                     end else begin
                        state_in = '0;
                     end
                  end
               end else if (stream_mode_ff && repeat_enable_ff) begin
                  state_in.phase_index   = '0;
                  state_in.phase_wait    = tbl_data;
                  state_in.led_on        = 1'b1;
                  state_in.elapsed_ticks = '0;
               end else begin
                  state_in = '0;
               end
            end
         end
         lbps_pkg::REQ_START: begin
            state_in.phase_wait    = stream_mode_ff ? tbl_data : fixed_interval_ff;
            state_in.active_phases = start_len;
            state_in.phase_index   = '0;
            state_in.elapsed_ticks = '0;
            state_in.led_on        = 1'b1;
            state_in.active        = 1'b1;
         end
         lbps_pkg::REQ_STOP: begin
            state_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pin_level_ff <= state_in.led_on ^ invert_output_ff;
         running_ff   <= state_in.active;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !state_ff.active |-> (!state_ff.led_on && state_ff.phase_index == '0
                            && state_ff.elapsed_ticks == '0))
      else $error("idle sequencer holds stale phase state");

   a_elapsed_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> (state_ff.elapsed_ticks <= {1'b0, state_ff.phase_wait}))
      else $error("elapsed count ran past the phase duration");

   a_stop_idles: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.req_type == lbps_pkg::REQ_STOP) |=> (!running_ff && rsp_valid_ff))
      else $error("stop request did not report idle");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.req_type == lbps_pkg::REQ_START)
         |=> (running_ff && state_ff.led_on && state_ff.phase_index == '0))
      else $error("start request did not begin phase zero");
`endif

endmodule
